>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while dis is high.
`define ASSERT_IMPLY(label, clk, dis, a, b) \
  label: assert property (@(posedge clk) disable iff (dis) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, skipped while dis is high.
`define ASSERT_NEXT(label, clk, dis, a, b) \
  label: assert property (@(posedge clk) disable iff (dis) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> hw/rtl/rau_pkg.sv
// Package for the rational arithmetic unit: beat types, codes, FSM types.
// Depends on nothing.
`timescale 1ns / 1ps
package rau_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FIELD_W       = 32;
  localparam int DEN_W         = 31;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_NEG = 4'd4;
  localparam logic [3:0] OP_EQ  = 4'd5;
  localparam logic [3:0] OP_NE  = 4'd6;
  localparam logic [3:0] OP_LT  = 4'd7;
  localparam logic [3:0] OP_LE  = 4'd8;
  localparam logic [3:0] OP_GT  = 4'd9;
  localparam logic [3:0] OP_GE  = 4'd10;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic [3:0]                operation;
    logic signed [FIELD_W-1:0] a_num;
    logic signed [FIELD_W-1:0] a_den;
    logic signed [FIELD_W-1:0] b_num;
    logic signed [FIELD_W-1:0] b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] res_num;
    logic [DEN_W-1:0]          res_den;
    logic                      truth;
    logic [1:0]                status;
  } rau_out_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_MUL, S_COMB, S_GCD, S_DIV, S_FINISH
  } rau_state_t;

  typedef enum logic [1:0] {
    K_FIXED, K_CMP, K_ARITH
  } rau_kind_t;

  typedef struct packed {
    logic load;
    logic mul_en;
    logic combine;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic out_load;
  } rau_cmd_t;

  typedef struct packed {
    logic fixed;
    logic cmp;
    logic mul_last;
    logic gcd_done;
    logic div_last;
  } rau_sts_t;

endpackage

>>> hw/rtl/rau_datapath.sv
// Datapath of the rational arithmetic unit: operand capture, shared multiplier,
// binary GCD, dual restoring divider, result register. Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_datapath import rau_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  rau_in_t  in_data,
  input  rau_cmd_t cmd,
  output rau_sts_t sts,
  output rau_out_t out_data
);

  localparam int PW = 2 * WORD_BITS;
  localparam int CW = $clog2(PW);
  localparam logic [PW-1:0] LIMIT = PW'(1) << (WORD_BITS - 1);

  logic [WORD_BITS-1:0] an_w, ad_w, bn_w, bd_w;
  logic [WORD_BITS-1:0] an_m, ad_m, bn_m, bd_m;
  rau_kind_t            kind_in;
  logic [1:0]           fix_st_in;

  logic [3:0]           op_r;
  logic                 sa_n, sa_d, sb_n, sb_d;
  logic [WORD_BITS-1:0] ma_n, ma_d, mb_n, mb_d;
  rau_kind_t            kind_r;
  logic [1:0]           fix_st;
  logic [1:0]           mul_idx;

  logic [WORD_BITS-1:0] mx, my;
  logic [PW-1:0]        prod;
  logic [PW-1:0]        p0, p1, p2;

  logic                 s0, s1, s1e, s2, same, ge;
  logic [PW-1:0]        sum_mag;
  logic                 sum_s;
  logic [PW-1:0]        n_mag, d_mag;
  logic                 n_s, d_s;
  logic                 lsn, rsn, c_eq, c_lt, c_truth;

  logic [PW-1:0]        nmag, dmag;
  logic                 ns, ds, truth_r;
  logic [PW-1:0]        x, y, g;
  logic [CW-1:0]        k;
  logic [PW-1:0]        qn, qd;
  logic [PW:0]          rn, rd, rn_s, rd_s;
  logic [CW-1:0]        dcnt;

  logic                 neg, ovf;
  logic [WORD_BITS-1:0] num_w;
  rau_out_t             out_next;

  function automatic logic [WORD_BITS-1:0] magof(input logic [WORD_BITS-1:0] v);
    magof = v[WORD_BITS-1] ? (~v + WORD_BITS'(1)) : v;
  endfunction

  // operand decode at load
  always_comb begin
    an_w = in_data.a_num[WORD_BITS-1:0];
    ad_w = in_data.a_den[WORD_BITS-1:0];
    bn_w = in_data.b_num[WORD_BITS-1:0];
    bd_w = in_data.b_den[WORD_BITS-1:0];
    an_m = magof(an_w);
    ad_m = magof(ad_w);
    bn_m = magof(bn_w);
    bd_m = magof(bd_w);
    fix_st_in = ST_OK;
    if (in_data.operation > OP_GE) begin
      kind_in = K_FIXED;
    end else if (ad_w == '0 || (in_data.operation != OP_NEG && bd_w == '0) ||
                 (in_data.operation == OP_DIV && bn_w == '0)) begin
      kind_in   = K_FIXED;
      fix_st_in = ST_ZERO;
    end else if (in_data.operation >= OP_EQ) begin
      kind_in = K_CMP;
    end else begin
      kind_in = K_ARITH;
    end
  end

  // multiplier operand select per step
  always_comb begin
    case (mul_idx)
      2'd0: begin
        mx = ma_n;
        my = (op_r == OP_MUL) ? mb_n : (op_r == OP_NEG) ? WORD_BITS'(1) : mb_d;
      end
      2'd1: begin
        mx = (op_r == OP_DIV) ? ma_d : mb_n;
        my = (op_r == OP_DIV) ? mb_n : ma_d;
      end
      default: begin
        mx = ma_d;
        my = (op_r == OP_NEG) ? WORD_BITS'(1) : mb_d;
      end
    endcase
    prod = PW'(mx) * PW'(my);
  end

  // combine products into signed numerator / denominator, and compare
  always_comb begin
    s0  = sa_n ^ ((op_r == OP_MUL) ? sb_n : (op_r == OP_NEG) ? 1'b0 : sb_d);
    s1  = sa_d ^ sb_n;
    s1e = s1 ^ (op_r == OP_SUB);
    s2  = sa_d ^ ((op_r == OP_NEG) ? 1'b0 : sb_d);
    same = (s0 == s1e);
    ge   = (p0 >= p1);
    if (same) begin
      sum_mag = p0 + p1;
      sum_s   = s0;
    end else if (ge) begin
      sum_mag = p0 - p1;
      sum_s   = s0;
    end else begin
      sum_mag = p1 - p0;
      sum_s   = s1e;
    end
    n_mag = p0;
    n_s   = s0;
    d_mag = p2;
    d_s   = s2;
    case (op_r)
      OP_ADD, OP_SUB: begin
        n_mag = sum_mag;
        n_s   = sum_s;
      end
      OP_DIV: begin
        d_mag = p1;
        d_s   = s1;
      end
      OP_NEG: n_s = ~s0;
      default: ;
    endcase
    lsn  = (sa_n ^ sa_d) && (p0 != '0);
    rsn  = (sb_n ^ sb_d) && (p1 != '0);
    c_eq = (lsn == rsn) && (p0 == p1);
    c_lt = (lsn && !rsn) || ((lsn == rsn) && (lsn ? (p0 > p1) : (p1 > p0)));
    case (op_r)
      OP_EQ:   c_truth = c_eq;
      OP_NE:   c_truth = !c_eq;
      OP_LT:   c_truth = c_lt;
      OP_LE:   c_truth = c_lt || c_eq;
      OP_GT:   c_truth = !(c_lt || c_eq);
      default: c_truth = !c_lt;
    endcase
  end

  assign rn_s = {rn[PW-1:0], qn[PW-1]};
  assign rd_s = {rd[PW-1:0], qd[PW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_idx <= '0;
    end else if (cmd.load) begin
      mul_idx <= '0;
    end else if (cmd.mul_en) begin
      mul_idx <= mul_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_data.operation;
      sa_n   <= an_w[WORD_BITS-1];
      sa_d   <= ad_w[WORD_BITS-1];
      sb_n   <= bn_w[WORD_BITS-1];
      sb_d   <= bd_w[WORD_BITS-1];
      ma_n   <= an_m;
      ma_d   <= ad_m;
      mb_n   <= bn_m;
      mb_d   <= bd_m;
      kind_r <= kind_in;
      fix_st <= fix_st_in;
    end
    if (cmd.mul_en) begin
      case (mul_idx)
        2'd0:    p0 <= prod;
        2'd1:    p1 <= prod;
        default: p2 <= prod;
      endcase
    end
    if (cmd.combine) begin
      nmag    <= n_mag;
      dmag    <= d_mag;
      ns      <= n_s;
      ds      <= d_s;
      x       <= n_mag;
      y       <= d_mag;
      k       <= '0;
      truth_r <= c_truth;
    end
    // binary GCD, one step a cycle
    if (cmd.gcd_step) begin
      if (!x[0] && !y[0]) begin
        x <= x >> 1;
        y <= y >> 1;
        k <= k + CW'(1);
      end else if (!x[0]) begin
        x <= x >> 1;
      end else if (!y[0]) begin
        y <= y >> 1;
      end else if (x >= y) begin
        x <= (x - y) >> 1;
      end else begin
        y <= (y - x) >> 1;
      end
    end
    if (cmd.div_init) begin
      g    <= (x | y) << k;
      qn   <= nmag;
      qd   <= dmag;
      rn   <= '0;
      rd   <= '0;
      dcnt <= '0;
    end
    // two restoring dividers share the divisor, one quotient bit a cycle
    if (cmd.div_step) begin
      dcnt <= dcnt + CW'(1);
      if (rn_s >= {1'b0, g}) begin
        rn <= rn_s - {1'b0, g};
        qn <= {qn[PW-2:0], 1'b1};
      end else begin
        rn <= rn_s;
        qn <= {qn[PW-2:0], 1'b0};
      end
      if (rd_s >= {1'b0, g}) begin
        rd <= rd_s - {1'b0, g};
        qd <= {qd[PW-2:0], 1'b1};
      end else begin
        rd <= rd_s;
        qd <= {qd[PW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    neg   = (qn != '0) && (ns != ds);
    ovf   = (qd > LIMIT - PW'(1)) || (qn > (neg ? LIMIT : LIMIT - PW'(1)));
    num_w = neg ? (~qn[WORD_BITS-1:0] + WORD_BITS'(1)) : qn[WORD_BITS-1:0];
  end

  always_comb begin
    out_next = '0;
    unique case (kind_r)
      K_FIXED: out_next.status = fix_st;
      K_CMP:   out_next.truth  = truth_r;
      K_ARITH: begin
        if (ovf) begin
          out_next.status = ST_OVF;
        end else begin
          out_next.res_num = FIELD_W'($signed(num_w));
          out_next.res_den = DEN_W'(qd);
        end
      end
      default: out_next.status = fix_st;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= out_next;
    end
  end

  always_comb begin
    sts.fixed    = (kind_r == K_FIXED);
    sts.cmp      = (kind_r == K_CMP);
    sts.mul_last = (mul_idx == 2'd2);
    sts.gcd_done = (x == '0) || (y == '0);
    sts.div_last = (dcnt == CW'(PW - 1));
  end

endmodule

>>> hw/rtl/rau_ctrl.sv
// Controller FSM of the rational arithmetic unit and output valid flag.
// Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_ctrl import rau_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  rau_sts_t sts,
  output rau_cmd_t cmd
);

  rau_state_t state, state_next;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_valid) state_next = S_DISPATCH;
      S_DISPATCH: state_next = sts.fixed ? S_FINISH : S_MUL;
      S_MUL:      if (sts.mul_last) state_next = S_COMB;
      S_COMB:     state_next = sts.cmp ? S_FINISH : S_GCD;
      S_GCD:      if (sts.gcd_done) state_next = S_DIV;
      S_DIV:      if (sts.div_last) state_next = S_FINISH;
      S_FINISH:   if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_DISPATCH: ;
      S_MUL:      cmd.mul_en   = 1'b1;
      S_COMB:     cmd.combine  = 1'b1;
      S_GCD: begin
        cmd.gcd_step = !sts.gcd_done;
        cmd.div_init = sts.gcd_done;
      end
      S_DIV:      cmd.div_step = 1'b1;
      S_FINISH:   cmd.out_load = out_free;
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/rational_arithmetic_unit_top.sv
// Top level of the rational arithmetic unit: controller plus datapath.
// Depends on rau_pkg, rau_ctrl, rau_datapath.
//
//   channel | direction | handshake          | beat
//   --------+-----------+--------------------+----------------------------------
//   in      | input     | in_valid/in_stall  | rau_in_t: op code, a and b
//   out     | output    | out_valid/out_stall| rau_out_t: num, den, truth, status
//
// Operation: one beat at a time. Error and unused codes skip the products, comparisons
// skip the GCD and divide, and arithmetic runs the three products, the binary GCD
// steps and then the shared dual restoring divider.
// Reset: synchronous on rst; clears the FSM and the output valid flag.
// Stalls: a finished beat waits in the output register; the next input beat is
// taken and computed meanwhile, and only the final handoff waits for out_stall.
`timescale 1ns / 1ps
module rational_arithmetic_unit_top import rau_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  rau_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output rau_out_t out_data
);

  rau_cmd_t cmd;
  rau_sts_t sts;

  // sequence the operation: capture, three products, combine, GCD, divide
  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // hold operands, products, GCD and quotient registers, and the result beat
  rau_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

>>> hw/rtl/rau_checker.sv
// Port-level checker for the rational arithmetic unit, bound to the top level.
// Depends on rau_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rau_checker import rau_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input rau_out_t out_data
);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
  `ASSERT_NEXT(a_rst_idle, clk, 1'b0, rst, !out_valid)
  `ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && !in_stall, in_stall)
  `ASSERT_IMPLY(a_err_zero, clk, rst, out_valid && out_data.status != ST_OK, out_data.res_num == '0 && out_data.res_den == '0 && !out_data.truth)
  `ASSERT_IMPLY(a_truth_only, clk, rst, out_valid && out_data.truth, out_data.res_num == '0 && out_data.res_den == '0)

endmodule

bind rational_arithmetic_unit_top rau_checker u_rau_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
